// ----- hw/rtl/ethp_pkg.sv -----
// Shared types and constants for the emulated time horizon pacer.
// No dependencies; used by every file in hw/rtl.
`timescale 1ns / 1ps
package ethp_pkg;

    localparam int TICK_W = 64;
    localparam int GEN_W  = 32;
    localparam int CMD_W  = 2;
    localparam int MODE_W = 2;
    localparam int CFG_W  = 2;

    // packed word sizes, padded to whole bytes
    localparam int IN_BITS  = MODE_W + 1 + 4 * TICK_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * TICK_W + 1 + GEN_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_UPDATE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_MODE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_PAUSE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_CPU      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REALTIME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HYBRID   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID  = 2'd3;

    localparam logic [CFG_W-1:0] CFG_HOST_RATE = 2'd0;
    localparam logic [CFG_W-1:0] CFG_CHIP_RATE = 2'd1;
    localparam logic [CFG_W-1:0] CFG_BACKLOG   = 2'd2;

    // quarter-second windows: rate / 4, only when rate >= 4
    localparam logic [TICK_W-1:0] MIN_RATE      = 64'd4;
    localparam int                QUARTER_SHIFT = 2;

endpackage

// ----- hw/rtl/ethp_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on ethp_pkg. Divisor must be nonzero.
`timescale 1ns / 1ps
module ethp_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ethp_pkg::TICK_W-1:0] dividend,
    input  logic [ethp_pkg::TICK_W-1:0] divisor,
    output logic [ethp_pkg::TICK_W-1:0] quotient,
    output logic [ethp_pkg::TICK_W-1:0] remainder,
    output logic                       done
);
    localparam int W  = ethp_pkg::TICK_W;
    localparam int CW = $clog2(W);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dvs_reg;
    logic          done_reg;

    logic [W:0]    shifted;
    logic [W:0]    trial;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = !trial[W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- hw/rtl/ethp_mul.sv -----
// 64 x 64 multiplier keeping the low 64 bits, built from one shared
// 32 x 32 multiplier over three partial products. Depends on ethp_pkg.
`timescale 1ns / 1ps
module ethp_mul
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ethp_pkg::TICK_W-1:0] a,
    input  logic [ethp_pkg::TICK_W-1:0] b,
    output logic [ethp_pkg::TICK_W-1:0] product,
    output logic                        done
);
    localparam int W = ethp_pkg::TICK_W;
    localparam int H = W / 2;

    logic [1:0]   cnt_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] prod_reg;
    logic [1:0]   psel_reg;
    logic         pv_reg;
    logic [W-1:0] acc_reg;
    logic         done_reg;

    logic [H-1:0] op_x;
    logic [H-1:0] op_y;
    logic [W-1:0] addend;

    // partial products: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                op_x = a_reg[H-1:0];
                op_y = b_reg[H-1:0];
            end
            2'd1:
            begin
                op_x = a_reg[H-1:0];
                op_y = b_reg[W-1:H];
            end
            default:
            begin
                op_x = a_reg[W-1:H];
                op_y = b_reg[H-1:0];
            end
        endcase
    end

    assign addend = (psel_reg == 2'd0) ? prod_reg : {prod_reg[H-1:0], {H{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd3;
            psel_reg <= 2'd0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 2'd0;
                pv_reg  <= 1'b0;
            end
            else
            begin
                pv_reg <= (cnt_reg != 2'd3);
                if (cnt_reg != 2'd3)
                begin
                    psel_reg <= cnt_reg;
                    cnt_reg  <= cnt_reg + 2'd1;
                end
                if (pv_reg && psel_reg == 2'd2)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else
        begin
            prod_reg <= W'(op_x) * W'(op_y);
            if (pv_reg)
            begin
                acc_reg <= acc_reg + addend;
            end
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;

endmodule

// ----- hw/rtl/emulated_time_horizon_pacer_top.sv -----
// Emulated time horizon pacer: top level with command sequencer and state.
// Depends on ethp_pkg, ethp_div and ethp_mul.
// Paths from accepting a word: set commands, ignored words and paused, cpu-driven or
// rebasing updates go from decide straight to finish; host-paced updates with no
// elapsed host time go through target, clamp and release; all other updates also run
// two divisions and two multiplies through the shared units before target.
// One word in flight: s_tready is high only while the sequencer is idle, so a new
// word is taken only once the previous result is loaded into the output register.
// Reset (rst_n, async, active low) clears config, pacer state and sequencer to zero.
`timescale 1ns / 1ps
module emulated_time_horizon_pacer_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    // config write port
    input  logic                          cfg_we,
    input  logic [ethp_pkg::CFG_W-1:0]    cfg_index,
    input  logic [ethp_pkg::TICK_W-1:0]   cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata fields, low bit up: new_mode[1:0], pause_request[2],
    // host_now[66:3], cpu_ticks[130:67], chipset_ticks[194:131],
    // rebase_ticks[258:195], zero pad
    input  logic [ethp_pkg::IN_W-1:0]     s_tdata,
    // s_tuser fields: command[1:0]
    input  logic [ethp_pkg::CMD_W-1:0]    s_tuser,
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata fields, low bit up: horizon[63:0], wall_target[127:64],
    // clamped[128], rebase_count[160:129], zero pad
    output logic [ethp_pkg::OUT_W-1:0]    m_tdata
);
    localparam int W  = ethp_pkg::TICK_W;
    localparam int GW = ethp_pkg::GEN_W;
    localparam int MW = ethp_pkg::MODE_W;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV1,
        ST_MUL1,
        ST_MUL2,
        ST_DIV2,
        ST_TARGET,
        ST_CLAMP,
        ST_RELEASE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration
    logic [W-1:0] host_rate_reg;
    logic [W-1:0] chip_rate_reg;
    logic [W-1:0] backlog_reg;

    // captured input word
    logic [ethp_pkg::CMD_W-1:0] cmd_reg;
    logic [MW-1:0]              new_mode_reg;
    logic                       pause_req_reg;
    logic [W-1:0]               now_reg;
    logic [W-1:0]               cpu_reg;
    logic [W-1:0]               chip_reg;
    logic [W-1:0]               rebase_reg;

    // pacer state
    logic [MW-1:0] mode_reg;
    logic          paused_reg;
    logic [W-1:0]  base_host_reg;
    logic [W-1:0]  last_host_reg;
    logic [W-1:0]  base_ticks_reg;
    logic [W-1:0]  horizon_reg;
    logic [W-1:0]  target_reg;
    logic          clamp_reg;
    logic [GW-1:0] gen_reg;

    // update scratch
    logic [W-1:0]  follow_reg;
    logic [W-1:0]  elapsed_reg;
    logic [W-1:0]  part_reg;
    logic [W-1:0]  prod_reg;
    logic [W-1:0]  tgt_reg;
    logic [W-1:0]  bound_reg;
    logic [W-1:0]  tval_reg;
    logic          prev_clamp_reg;

    // shared unit control
    logic          div_start_reg;
    logic [W-1:0]  div_a_reg;
    logic          mul_start_reg;
    logic [W-1:0]  mul_a_reg;
    logic [W-1:0]  div_q;
    logic [W-1:0]  div_r;
    logic          div_done;
    logic [W-1:0]  mul_p;
    logic          mul_done;

    // output word
    logic                      out_valid_reg;
    logic [ethp_pkg::OUT_W-1:0] out_data_reg;
    logic                      out_load;

    // combinational terms for the decide, target and release states
    logic [W-1:0] gap;
    logic         host_jump;
    logic         no_elapsed;
    logic [W-1:0] delta;
    logic [W:0]   bound_sum;
    logic [W-1:0] rel_diff;
    logic         release_hit;

    assign gap        = now_reg - last_host_reg;
    // host discontinuity: counter went back or skipped over a quarter second
    assign host_jump  = (now_reg < last_host_reg) ||
                        ((host_rate_reg >= ethp_pkg::MIN_RATE) &&
                         (gap > (host_rate_reg >> ethp_pkg::QUARTER_SHIFT)));
    assign no_elapsed = (now_reg <= base_host_reg) || (host_rate_reg == '0);
    assign delta      = now_reg - base_host_reg;

    // saturating clamp bound
    assign bound_sum  = {1'b0, follow_reg} + {1'b0, backlog_reg};

    // clamp release: big deficit right after the clamp lets go
    assign rel_diff    = tval_reg - horizon_reg;
    assign release_hit = prev_clamp_reg && !clamp_reg &&
                         (chip_rate_reg >= ethp_pkg::MIN_RATE) &&
                         (tval_reg > horizon_reg) &&
                         (rel_diff > (chip_rate_reg >> ethp_pkg::QUARTER_SHIFT));

    // result register takes a new word when empty or being drained
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);

    ethp_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_a_reg),
        .divisor   (host_rate_reg),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    ethp_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (chip_rate_reg),
        .product (mul_p),
        .done    (mul_done)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            host_rate_reg  <= '0;
            chip_rate_reg  <= '0;
            backlog_reg    <= '0;
            mode_reg       <= ethp_pkg::MODE_CPU;
            paused_reg     <= 1'b0;
            base_host_reg  <= '0;
            last_host_reg  <= '0;
            base_ticks_reg <= '0;
            horizon_reg    <= '0;
            target_reg     <= '0;
            clamp_reg      <= 1'b0;
            gen_reg        <= '0;
            prev_clamp_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            mul_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            mul_start_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    ethp_pkg::CFG_HOST_RATE: host_rate_reg <= cfg_data;
                    ethp_pkg::CFG_CHIP_RATE: chip_rate_reg <= cfg_data;
                    ethp_pkg::CFG_BACKLOG:   backlog_reg   <= cfg_data;
                    default:                 ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg       <= s_tuser;
                        new_mode_reg  <= s_tdata[1:0];
                        pause_req_reg <= s_tdata[2];
                        now_reg       <= s_tdata[66:3];
                        cpu_reg       <= s_tdata[130:67];
                        chip_reg      <= s_tdata[194:131];
                        rebase_reg    <= s_tdata[258:195];
                        state_reg     <= ST_DECIDE;
                    end
                end

                ST_DECIDE:
                begin
                    state_reg <= ST_FINISH;
                    case (cmd_reg)
                        ethp_pkg::CMD_UPDATE:
                        begin
                            if (!paused_reg)
                            begin
                                if (mode_reg != ethp_pkg::MODE_CPU && host_jump)
                                begin
                                    // rebase onto the current horizon
                                    base_host_reg  <= now_reg;
                                    last_host_reg  <= now_reg;
                                    base_ticks_reg <= horizon_reg;
                                    target_reg     <= horizon_reg;
                                    clamp_reg      <= 1'b0;
                                    gen_reg        <= gen_reg + GW'(1);
                                end
                                else
                                begin
                                    last_host_reg <= now_reg;
                                    if (mode_reg == ethp_pkg::MODE_CPU)
                                    begin
                                        target_reg <= cpu_reg;
                                        clamp_reg  <= 1'b0;
                                        if (cpu_reg > horizon_reg)
                                        begin
                                            horizon_reg <= cpu_reg;
                                        end
                                    end
                                    else
                                    begin
                                        follow_reg <= (mode_reg == ethp_pkg::MODE_HYBRID &&
                                                       cpu_reg < chip_reg) ?
                                                      cpu_reg : chip_reg;
                                        if (no_elapsed)
                                        begin
                                            elapsed_reg <= '0;
                                            state_reg   <= ST_TARGET;
                                        end
                                        else
                                        begin
                                            div_a_reg     <= delta;
                                            div_start_reg <= 1'b1;
                                            state_reg     <= ST_DIV1;
                                        end
                                    end
                                end
                            end
                        end

                        ethp_pkg::CMD_SET_MODE:
                        begin
                            if (new_mode_reg != ethp_pkg::MODE_INVALID)
                            begin
                                mode_reg       <= new_mode_reg;
                                base_host_reg  <= now_reg;
                                last_host_reg  <= now_reg;
                                base_ticks_reg <= rebase_reg;
                                horizon_reg    <= rebase_reg;
                                target_reg     <= rebase_reg;
                                clamp_reg      <= 1'b0;
                                gen_reg        <= gen_reg + GW'(1);
                            end
                        end

                        ethp_pkg::CMD_SET_PAUSE:
                        begin
                            if (paused_reg != pause_req_reg)
                            begin
                                paused_reg     <= pause_req_reg;
                                base_host_reg  <= now_reg;
                                last_host_reg  <= now_reg;
                                base_ticks_reg <= rebase_reg;
                                horizon_reg    <= rebase_reg;
                                target_reg     <= rebase_reg;
                                clamp_reg      <= 1'b0;
                                gen_reg        <= gen_reg + GW'(1);
                            end
                        end

                        default:
                        begin
                            // unused command code: report state only
                        end
                    endcase
                end

                // whole seconds and remainder of the host delta
                ST_DIV1:
                begin
                    if (div_done)
                    begin
                        part_reg      <= div_r;
                        mul_a_reg     <= div_q;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL1;
                    end
                end

                ST_MUL1:
                begin
                    if (mul_done)
                    begin
                        prod_reg      <= mul_p;
                        mul_a_reg     <= part_reg;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_MUL2;
                    end
                end

                ST_MUL2:
                begin
                    if (mul_done)
                    begin
                        div_a_reg     <= mul_p;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV2;
                    end
                end

                ST_DIV2:
                begin
                    if (div_done)
                    begin
                        elapsed_reg <= prod_reg + div_q;
                        state_reg   <= ST_TARGET;
                    end
                end

                ST_TARGET:
                begin
                    tgt_reg    <= base_ticks_reg + elapsed_reg;
                    target_reg <= base_ticks_reg + elapsed_reg;
                    bound_reg  <= bound_sum[W] ? {W{1'b1}} : bound_sum[W-1:0];
                    state_reg  <= ST_CLAMP;
                end

                ST_CLAMP:
                begin
                    prev_clamp_reg <= clamp_reg;
                    if (tgt_reg > bound_reg)
                    begin
                        tval_reg  <= bound_reg;
                        clamp_reg <= 1'b1;
                    end
                    else
                    begin
                        tval_reg  <= tgt_reg;
                        clamp_reg <= 1'b0;
                    end
                    state_reg <= ST_RELEASE;
                end

                ST_RELEASE:
                begin
                    if (release_hit)
                    begin
                        // restart the timeline at the horizon, no generation bump
                        base_host_reg  <= now_reg;
                        base_ticks_reg <= horizon_reg;
                        target_reg     <= horizon_reg;
                    end
                    else if (tval_reg > horizon_reg)
                    begin
                        horizon_reg <= tval_reg;
                    end
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (out_load)
                    begin
                        out_data_reg <= ethp_pkg::OUT_W'({gen_reg, clamp_reg,
                                                          target_reg, horizon_reg});
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
